// ===== src/lmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsf_pkg
// Shared types and fixed-point constants for the LMS adaptive FIR.
// ----------------------------------------------------------------------------
package lmsf_pkg;

	localparam int X_W    = 16;        // Q1.15 sample
	localparam int W_W    = 24;        // Q4.20 weight
	localparam int STEP_W = 16;        // Q0.16 step size

	localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;   // ~0.005

	localparam int W_MAX = 8388607;
	localparam int W_MIN = -8388608;
	localparam int S_MAX = 32767;
	localparam int S_MIN = -32768;

	localparam int Y_FRAC_SH = 20;     // Q.35 accumulator -> Q.15
	localparam int D_FRAC_SH = 26;     // Q.46 update product -> Q.20

	// per-cell load strobes
	typedef struct packed {
		logic load_x;   // take neighbor's sample
		logic load_w;   // take neighbor's weight
	} cell_ctl_t;

	// control into the shared MAC / update unit
	typedef struct packed {
		logic rot;      // ring is rotating this cycle
		logic vld;      // tail entry is a real tap
		logic upd;      // 1: weight update pass, 0: dot product pass
		logic acc_clr;  // clear accumulator
	} mac_ctl_t;

endpackage

// ===== src/lmsf_cell.sv =====
// ----------------------------------------------------------------------------
// lmsf_cell
// One tap: holds a sample and its weight, loads from the neighbor.
// ----------------------------------------------------------------------------
module lmsf_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lmsf_pkg::cell_ctl_t                 ctl,
	input  logic signed [lmsf_pkg::X_W-1:0]     x_prev,
	input  logic signed [lmsf_pkg::W_W-1:0]     w_prev,
	output logic signed [lmsf_pkg::X_W-1:0]     x,
	output logic signed [lmsf_pkg::W_W-1:0]     w
);

	logic signed [lmsf_pkg::X_W-1:0] x_q;
	logic signed [lmsf_pkg::W_W-1:0] w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			w_q <= '0;
		end else begin
			if (ctl.load_x) begin
				x_q <= x_prev;
			end
			if (ctl.load_w) begin
				w_q <= w_prev;
			end
		end
	end

	assign x = x_q;
	assign w = w_q;

endmodule

// ===== src/lmsf_mac.sv =====
// ----------------------------------------------------------------------------
// lmsf_mac
// Shared multiplier sitting in the ring: accumulates w*x on the first pass,
// applies w += round(se*x) with saturation on the second pass.
// ----------------------------------------------------------------------------
module lmsf_mac #(
	parameter int ACC_W = 46,
	parameter int SE_W  = 44
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lmsf_pkg::mac_ctl_t                  ctl,
	input  logic signed [lmsf_pkg::X_W-1:0]     x_tail,
	input  logic signed [lmsf_pkg::W_W-1:0]     w_tail,
	input  logic signed [SE_W-1:0]              se,
	output logic signed [lmsf_pkg::X_W-1:0]     x_out,
	output logic signed [lmsf_pkg::W_W-1:0]     w_out,
	output logic signed [ACC_W-1:0]             acc
);

	localparam int PROD_W = SE_W + lmsf_pkg::X_W;
	localparam int RND_W  = PROD_W + 1 - lmsf_pkg::D_FRAC_SH;
	localparam int SUM_W  = RND_W + 1;

	localparam logic signed [SUM_W-1:0] WMAX = SUM_W'(lmsf_pkg::W_MAX);
	localparam logic signed [SUM_W-1:0] WMIN = SUM_W'(lmsf_pkg::W_MIN);
	localparam logic signed [PROD_W:0]  HALF = (PROD_W+1)'(1) <<< (lmsf_pkg::D_FRAC_SH - 1);

	logic signed [SE_W-1:0]             op;
	logic signed [PROD_W-1:0]           mul;
	logic signed [PROD_W-1:0]           prod_s1;
	logic signed [lmsf_pkg::X_W-1:0]    x_s1, x_s2;
	logic signed [lmsf_pkg::W_W-1:0]    w_s1, w_s2;
	logic                               vld_s1, upd_s1;
	logic signed [PROD_W:0]             prod_rnd;
	logic signed [RND_W-1:0]            delta;
	logic signed [SUM_W-1:0]            w_sum;
	logic signed [lmsf_pkg::W_W-1:0]    w_new;
	logic signed [ACC_W-1:0]            acc_q;

	// one multiplier, operand picked by pass
	assign op  = ctl.upd ? se : SE_W'(w_tail);
	assign mul = op * x_tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			upd_s1 <= 1'b0;
		end else if (ctl.rot) begin
			vld_s1 <= ctl.vld;
			upd_s1 <= ctl.upd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rot) begin
			prod_s1 <= mul;
			x_s1    <= x_tail;
			w_s1    <= w_tail;
			x_s2    <= x_s1;
			w_s2    <= upd_s1 ? w_new : w_s1;
		end
	end

	// round to Q.20, add, clamp to weight range
	assign prod_rnd = {prod_s1[PROD_W-1], prod_s1} + HALF;
	assign delta    = prod_rnd[PROD_W:lmsf_pkg::D_FRAC_SH];
	assign w_sum    = SUM_W'(w_s1) + SUM_W'(delta);

	always_comb begin
		if (w_sum > WMAX) begin
			w_new = lmsf_pkg::W_W'(WMAX);
		end else if (w_sum < WMIN) begin
			w_new = lmsf_pkg::W_W'(WMIN);
		end else begin
			w_new = w_sum[lmsf_pkg::W_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.rot && vld_s1 && !upd_s1) begin
			acc_q <= acc_q + prod_s1[ACC_W-1:0];
		end
	end

	assign x_out = x_s2;
	assign w_out = w_s2;
	assign acc   = acc_q;

endmodule

// ===== src/lms_adaptive_fir.sv =====
// ----------------------------------------------------------------------------
// lms_adaptive_fir
// LMS adaptive FIR: a ring of tap cells circulating past one shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one Q1.15 noise_sample word.
//   Output channel out_valid/out_ready carries drive_sample (-y) and
//   error_sample (x - y), both saturated Q1.15.
//   cfg_wr_en/cfg_wr_data write step_size (Q0.16); write only while idle.
// Sequence:
//   Accepted word shifts into tap 0, then the ring of NUM_TAPS cells plus
//   the two MAC stages rotates once in ST_DOT for the dot product, ST_ERR
//   forms y and e, ST_SE forms step*e, and ST_UPD rotates the ring once
//   more to update the weights. Result is registered in ST_DONE; a new
//   word is taken only back in ST_IDLE, after the result is registered;
//   the single shared multiplier at the end of the ring serves both passes.
// Reset: taps and weights clear to zero, step_size returns to 328.
// Stall: the result waits in the output register; the next word is
//   accepted and processed, and only its writeback waits for the slot.
// ----------------------------------------------------------------------------
module lms_adaptive_fir #(
	parameter int NUM_TAPS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [lmsf_pkg::X_W-1:0]     noise_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lmsf_pkg::X_W-1:0]     drive_sample,
	output logic signed [lmsf_pkg::X_W-1:0]     error_sample,
	input  logic                                cfg_wr_en,
	input  logic [lmsf_pkg::STEP_W-1:0]         cfg_wr_data
);

	localparam int CNT_W = $clog2(NUM_TAPS + 2);
	localparam int ACC_W = lmsf_pkg::W_W + lmsf_pkg::X_W + $clog2(NUM_TAPS);
	localparam int Y_W   = ACC_W + 1 - lmsf_pkg::Y_FRAC_SH;
	localparam int E_W   = Y_W + 1;
	localparam int SE_W  = lmsf_pkg::STEP_W + 1 + E_W;

	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_TAPS + 1);
	localparam logic [CNT_W-1:0] NT   = CNT_W'(NUM_TAPS);

	localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(1) <<< (lmsf_pkg::Y_FRAC_SH - 1);
	localparam logic signed [E_W-1:0] SMAX = E_W'(lmsf_pkg::S_MAX);
	localparam logic signed [E_W-1:0] SMIN = E_W'(lmsf_pkg::S_MIN);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DOT  = 3'd1;
	localparam logic [2:0] ST_ERR  = 3'd2;
	localparam logic [2:0] ST_SE   = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]                         state_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [lmsf_pkg::STEP_W-1:0]        step_q;
	logic                               accept;
	logic                               rot;
	logic                               out_free;

	logic signed [lmsf_pkg::X_W-1:0]    x_chain [NUM_TAPS];
	logic signed [lmsf_pkg::W_W-1:0]    w_chain [NUM_TAPS];
	logic signed [lmsf_pkg::X_W-1:0]    x_head, x_ring;
	logic signed [lmsf_pkg::W_W-1:0]    w_ring;
	lmsf_pkg::cell_ctl_t                cell_ctl;
	lmsf_pkg::mac_ctl_t                 mac_ctl;
	logic signed [ACC_W-1:0]            acc;

	logic signed [ACC_W:0]              acc_rnd;
	logic signed [Y_W-1:0]              y;
	logic signed [E_W-1:0]              e_now;
	logic signed [E_W-1:0]              e_q;
	logic signed [E_W-1:0]              neg_y_q;
	logic signed [SE_W-1:0]             se_q;
	logic signed [lmsf_pkg::X_W-1:0]    drive_q, error_q;
	logic                               out_valid_q;
	logic signed [lmsf_pkg::X_W-1:0]    drive_sat, error_sat;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign rot      = (state_q == ST_DOT) || (state_q == ST_UPD);
	assign out_free = !out_valid_q || out_ready;

	// step size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lmsf_pkg::STEP_RESET;
		end else if (cfg_wr_en) begin
			step_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					state_q <= ST_SE;
				end
				ST_SE: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// new word shifts the sample chain; rotation moves sample and weight
	assign cell_ctl.load_x = accept || rot;
	assign cell_ctl.load_w = rot;
	assign x_head          = rot ? x_ring : noise_sample;

	assign mac_ctl.rot     = rot;
	assign mac_ctl.vld     = rot && (cnt_q < NT);
	assign mac_ctl.upd     = (state_q == ST_UPD);
	assign mac_ctl.acc_clr = accept;

	for (genvar i = 0; i < NUM_TAPS; i++) begin : g_tap
		if (i == 0) begin : g_head
			lmsf_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (cell_ctl),
				.x_prev (x_head),
				.w_prev (w_ring),
				.x      (x_chain[i]),
				.w      (w_chain[i])
			);
		end else begin : g_body
			lmsf_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (cell_ctl),
				.x_prev (x_chain[i-1]),
				.w_prev (w_chain[i-1]),
				.x      (x_chain[i]),
				.w      (w_chain[i])
			);
		end
	end

	lmsf_mac #(
		.ACC_W (ACC_W),
		.SE_W  (SE_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x_tail (x_chain[NUM_TAPS-1]),
		.w_tail (w_chain[NUM_TAPS-1]),
		.se     (se_q),
		.x_out  (x_ring),
		.w_out  (w_ring),
		.acc    (acc)
	);

	// y = round(acc) to Q.15 (ties up); e = x - y, both unsaturated
	assign acc_rnd = {acc[ACC_W-1], acc} + HALF;
	assign y       = acc_rnd[ACC_W:lmsf_pkg::Y_FRAC_SH];
	assign e_now   = E_W'(x_chain[0]) - E_W'(y);

	always_ff @(posedge clk) begin
		if (state_q == ST_ERR) begin
			e_q     <= e_now;
			neg_y_q <= -E_W'(y);
		end
		if (state_q == ST_SE) begin
			se_q <= $signed({1'b0, step_q}) * e_q;
		end
	end

	always_comb begin
		if (neg_y_q > SMAX) begin
			drive_sat = lmsf_pkg::X_W'(SMAX);
		end else if (neg_y_q < SMIN) begin
			drive_sat = lmsf_pkg::X_W'(SMIN);
		end else begin
			drive_sat = neg_y_q[lmsf_pkg::X_W-1:0];
		end
		if (e_q > SMAX) begin
			error_sat = lmsf_pkg::X_W'(SMAX);
		end else if (e_q < SMIN) begin
			error_sat = lmsf_pkg::X_W'(SMIN);
		end else begin
			error_sat = e_q[lmsf_pkg::X_W-1:0];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			drive_q <= drive_sat;
			error_q <= error_sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_sample = drive_q;
	assign error_sample = error_q;

endmodule

// ===== test/lms_adaptive_fir_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lms_adaptive_fir_test
// Self-checking bench for the 64-tap LMS adaptive FIR.
// A directed list of words and step_size writes runs first. Random phases
// follow, each with its own step_size. Every accepted noise word goes
// through a bit-exact fixed-point copy of the filter, and each drive/error
// word that comes back is compared against it, oldest first.
// ----------------------------------------------------------------------------
module lms_adaptive_fir_test;

	localparam int NUM_TAPS    = 64;
	localparam int RAND_PHASES = 10;
	localparam int RAND_WORDS  = 1630;               // split evenly over the phases
	localparam int SETTLE      = 2*NUM_TAPS + 16;    // both passes of the ring plus margin
	localparam int RUN_LIMIT   = 5_000_000;          // watchdog bound on cycle_count

	// directed list: plain word, word with its result typed in, or step_size write
	typedef enum logic [1:0] {ROW_SAMPLE, ROW_TYPED, ROW_STEP} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [15:0]                     value;    // noise word or step_size
		logic signed [lmsf_pkg::X_W-1:0] drive;    // used by ROW_TYPED only
		logic signed [lmsf_pkg::X_W-1:0] err;
	} stim_row_t;

	typedef struct packed {
		logic signed [lmsf_pkg::X_W-1:0] drive;
		logic signed [lmsf_pkg::X_W-1:0] err;
	} lms_out_t;

	// Rows typed in are the ones where the weights are still all zero,
	// so y = 0 and the output is just (0, x).
	localparam stim_row_t DIRECTED [26] = '{
		'{ROW_TYPED,  16'h0000, 16'sd0, 16'sd0},      // reset state, x = 0 leaves weights at zero
		'{ROW_TYPED,  16'h4000, 16'sd0, 16'sd16384},  // still zero weights; first update at reset mu
		'{ROW_SAMPLE, 16'h7FFF, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h8000, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'hFFFF, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h0001, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h5555, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'hAAAA, 16'sd0, 16'sd0},
		'{ROW_STEP,   16'h0000, 16'sd0, 16'sd0},      // mu = 0: weights frozen
		'{ROW_SAMPLE, 16'h7FFF, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h8000, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h3039, 16'sd0, 16'sd0},
		'{ROW_STEP,   16'hFFFF, 16'sd0, 16'sd0},      // largest mu: drives weights and outputs to the rails
		'{ROW_SAMPLE, 16'h7FFF, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h8000, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h7FFF, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h8000, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h7FFF, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h8000, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h7FFF, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h8000, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h0000, 16'sd0, 16'sd0},
		'{ROW_STEP,   16'h0001, 16'sd0, 16'sd0},      // smallest nonzero mu
		'{ROW_SAMPLE, 16'h8000, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h7FFF, 16'sd0, 16'sd0},
		'{ROW_SAMPLE, 16'h0000, 16'sd0, 16'sd0}
	};

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              in_valid     = 1'b0;
	logic                              in_ready;
	logic signed [lmsf_pkg::X_W-1:0]   noise_sample = '0;
	logic                              out_valid;
	logic                              out_ready    = 1'b0;
	logic signed [lmsf_pkg::X_W-1:0]   drive_sample;
	logic signed [lmsf_pkg::X_W-1:0]   error_sample;
	logic                              cfg_wr_en    = 1'b0;
	logic [lmsf_pkg::STEP_W-1:0]       cfg_wr_data  = '0;

	// filter copy: delay line, weights, step size
	logic signed [lmsf_pkg::X_W-1:0]   tap_line   [NUM_TAPS];
	logic signed [lmsf_pkg::W_W-1:0]   weight_mem [NUM_TAPS];
	logic [lmsf_pkg::STEP_W-1:0]       mu_q016;

	lms_out_t                filter_out_q [$];   // drive/error words still owed by the DUT
	int                      mismatch_count = 0;
	int                      cycle_count    = 0;
	int                      stall_left     = 0;
	bit                      steady_run     = 1'b0;   // both sides stop idling

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	lms_adaptive_fir #(
		.NUM_TAPS     (NUM_TAPS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.noise_sample (noise_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.drive_sample (drive_sample),
		.error_sample (error_sample),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	function automatic logic signed [lmsf_pkg::X_W-1:0] clamp_q15(input longint v);
		if (v > lmsf_pkg::S_MAX)
			v = lmsf_pkg::S_MAX;
		else if (v < lmsf_pkg::S_MIN)
			v = lmsf_pkg::S_MIN;
		return v[lmsf_pkg::X_W-1:0];
	endfunction

	// One sample through the filter: shift in, dot product, round to Q1.15,
	// then update every weight with the unsaturated error.
	function automatic lms_out_t lms_advance(input logic signed [lmsf_pkg::X_W-1:0] x);
		longint   acc;
		longint   y;
		longint   e;
		longint   p;
		longint   w;
		lms_out_t res;
		for (int i = NUM_TAPS - 1; i > 0; i--)
			tap_line[i] = tap_line[i-1];
		tap_line[0] = x;

		// Q4.20 x Q1.15 products, 35 fraction bits, exact in 64 bits
		acc = 0;
		for (int i = 0; i < NUM_TAPS; i++)
			acc += longint'(weight_mem[i]) * longint'(tap_line[i]);

		// round half up: add half an LSB, then floor shift
		y = (acc + (longint'(1) <<< (lmsf_pkg::Y_FRAC_SH - 1))) >>> lmsf_pkg::Y_FRAC_SH;
		e = longint'(x) - y;

		// mu * e * tap has 46 fraction bits; round to Q4.20 and saturate
		for (int i = 0; i < NUM_TAPS; i++) begin
			p = longint'(mu_q016) * e * longint'(tap_line[i]);
			w = longint'(weight_mem[i]) +
				((p + (longint'(1) <<< (lmsf_pkg::D_FRAC_SH - 1))) >>> lmsf_pkg::D_FRAC_SH);
			if (w > lmsf_pkg::W_MAX)
				w = lmsf_pkg::W_MAX;
			else if (w < lmsf_pkg::W_MIN)
				w = lmsf_pkg::W_MIN;
			weight_mem[i] = w[lmsf_pkg::W_W-1:0];
		end

		// outputs clamp only at the port
		res.drive = clamp_q15(-y);
		res.err   = clamp_q15(e);
		return res;
	endfunction

	// Half full-scale noise; the rest quiet words, rail values and a slow
	// random walk so the filter has something it can actually track.
	function automatic logic signed [lmsf_pkg::X_W-1:0] pick_noise(
			input logic signed [lmsf_pkg::X_W-1:0] prev);
		int mode;
		mode = $urandom_range(99);
		if (mode < 50)
			return lmsf_pkg::X_W'($urandom);
		else if (mode < 70)
			return lmsf_pkg::X_W'(int'($urandom_range(1024)) - 512);
		else if (mode < 85) begin
			case ($urandom_range(3))
				0: return 16'sh7FFF;
				1: return 16'sh8000;
				2: return 16'sh0000;
				default: return 16'shFFFF;
			endcase
		end
		return prev + lmsf_pkg::X_W'(int'($urandom_range(2048)) - 1024);
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Present one noise word. valid is only dropped for an idle gap, so a
	// back-to-back word keeps valid high with a single assignment per edge.
	task automatic send_noise(input logic signed [lmsf_pkg::X_W-1:0] x, input bit typed,
			input lms_out_t typed_out);
		lms_out_t res;
		// occasional long gap moves the next word across all phases of the ring
		if (!steady_run && $urandom_range(7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 160)) @(posedge clk);
		end
		while (!steady_run && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		noise_sample <= x;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = lms_advance(x);
		filter_out_q.push_back(typed ? typed_out : res);
	endtask

	// Hold off the input until every owed word is back, then let the ring settle.
	task automatic drain_filter;
		in_valid <= 1'b0;
		while (filter_out_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_step(input logic [lmsf_pkg::STEP_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		mu_q016      = v;
	endtask

	initial begin : stimulus
		logic signed [lmsf_pkg::X_W-1:0] x_prev;
		logic [lmsf_pkg::STEP_W-1:0]     mu_pick;
		for (int i = 0; i < NUM_TAPS; i++) begin
			tap_line[i]   = '0;
			weight_mem[i] = '0;
		end
		mu_q016 = lmsf_pkg::STEP_RESET;
		x_prev  = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < $size(DIRECTED); r++) begin
			if (DIRECTED[r].kind == ROW_STEP) begin
				drain_filter();
				write_step(DIRECTED[r].value);
			end else begin
				send_noise(DIRECTED[r].value, DIRECTED[r].kind == ROW_TYPED,
					{DIRECTED[r].drive, DIRECTED[r].err});
			end
		end

		// random phases; the step write between them only happens with the ring idle
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: mu_pick = 16'hFFFF;
				1: mu_pick = 16'h0000;
				2: mu_pick = 16'h0001;
				3: mu_pick = lmsf_pkg::STEP_RESET;
				default: begin
					case ($urandom_range(2))
						0: mu_pick = lmsf_pkg::STEP_W'($urandom_range(65535));
						1: mu_pick = lmsf_pkg::STEP_W'($urandom_range(2048));
						default: mu_pick = lmsf_pkg::STEP_RESET;
					endcase
				end
			endcase
			drain_filter();
			write_step(mu_pick);
			steady_run = (ph == 3);   // one phase at full rate on both sides
			for (int n = 0; n < RAND_WORDS / RAND_PHASES; n++) begin
				x_prev = pick_noise(x_prev);
				send_noise(x_prev, 1'b0, '0);
			end
			steady_run = 1'b0;
		end

		drain_filter();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && filter_out_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Output side: compare each accepted word with the oldest owed one,
	// and drive out_ready with short random stalls and rare long ones.
	always @(posedge clk) begin : out_monitor
		lms_out_t head;
		cycle_count++;
		if (arst_n && out_valid && out_ready) begin
			if (filter_out_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected word: drive %0d, error %0d",
					drive_sample, error_sample));
			end else begin
				head = filter_out_q.pop_front();
				if (drive_sample !== head.drive)
					flag_mismatch($sformatf("drive_sample expected %0d, got %0d",
						head.drive, drive_sample));
				if (error_sample !== head.err)
					flag_mismatch($sformatf("error_sample expected %0d, got %0d",
						head.err, error_sample));
			end
		end

		if (steady_run)
			out_ready <= 1'b1;
		else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(599) == 0) begin
			// long stall: the next word's writeback has to wait for the slot
			stall_left = $urandom_range(20, 300);
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= 19);
	end

	initial begin : watchdog
		wait (cycle_count >= RUN_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

endmodule
